### src/fhss_pkg.sv
package fhss_pkg;

    localparam int HEIGHT_BITS    = 16;
    localparam int TABLE_ROWS     = 5;
    localparam int ROW_BITS       = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
    localparam int STEP_BITS      = 3;
    localparam int TOL_BITS       = HEIGHT_BITS - 1;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = HEIGHT_BITS;

    typedef logic signed [HEIGHT_BITS-1:0] height_t;
    typedef logic [ROW_BITS-1:0]           row_t;
    typedef logic [STEP_BITS-1:0]          step_t;
    typedef logic [TOL_BITS-1:0]           tol_t;
    typedef logic [CFG_INDEX_BITS-1:0]     cfg_index_t;

    typedef struct packed {
        height_t hi;
        height_t lo;
    } pair_t;

    localparam int PAIR_BITS = $bits(pair_t);

    localparam cfg_index_t REG_MODE      = 3'd0;
    localparam cfg_index_t REG_UPPER     = 3'd1;
    localparam cfg_index_t REG_LOWER     = 3'd2;
    localparam cfg_index_t REG_TOLERANCE = 3'd3;
    localparam cfg_index_t REG_LAST_STEP = 3'd4;

    localparam logic    MODE_RESET      = 1'b0;
    localparam height_t UPPER_RESET     = HEIGHT_BITS'(-8500);
    localparam height_t LOWER_RESET     = HEIGHT_BITS'(-10500);
    localparam tol_t    TOLERANCE_RESET = TOL_BITS'(350);
    localparam step_t   LAST_STEP_RESET = STEP_BITS'(4);

    localparam row_t ROW_OFS_2 = ROW_BITS'(2 % TABLE_ROWS);
    localparam row_t ROW_OFS_4 = ROW_BITS'(4 % TABLE_ROWS);
    localparam row_t ROW_LAST  = ROW_BITS'(TABLE_ROWS - 1);

endpackage

### src/foot_height_step_schedule_top.sv
// Foot height step schedule. Each word on the item channel is one gait step with four
// terrain heights; each is snapped to the target bound when closer than the tolerance,
// then clamped, and written into a ring table of TABLE_ROWS rows held in two RAMs of
// TABLE_ROWS entries (one for feet 0/3, one for feet 1/4; feet 2/5 always show the
// current step). Each item goes through a stage register and the output register; a new
// item is taken every cycle while the result side keeps up: each RAM does one write and
// one read per item. Refills (reset, mode write, end of run) take effect at once through
// per-row valid bits and a captured fill height, so there is no clearing pass.
module foot_height_step_schedule_top
    import fhss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  height_t     height_a,
    input  height_t     height_b,
    input  height_t     height_c,
    input  height_t     height_d,
    output logic        result_valid,
    input  logic        result_stall,
    output height_t     foot_0,
    output height_t     foot_1,
    output height_t     foot_2,
    output height_t     foot_3,
    output height_t     foot_4,
    output height_t     foot_5,
    output step_t       step_number,
    output logic        run_done,
    output height_t     clamped_a,
    output height_t     clamped_b,
    output height_t     clamped_c,
    output height_t     clamped_d,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    function automatic height_t shape(height_t h, logic m, height_t up, height_t lo,
                                      tol_t tol);
        logic signed [HEIGHT_BITS:0] d;
        logic [HEIGHT_BITS:0]        mag;
        height_t                     tgt;
        height_t                     v;
        tgt = m ? lo : up;
        d   = {h[HEIGHT_BITS-1], h} - {tgt[HEIGHT_BITS-1], tgt};
        mag = d[HEIGHT_BITS] ? -d : d;
        v   = (mag < (HEIGHT_BITS+1)'(tol)) ? tgt : h;
        if (!m)
        begin
            if (v > up) v = up;
            if (v < lo) v = lo;
        end
        else
        begin
            if (v < lo) v = lo;
            if (v > up) v = up;
        end
        return v;
    endfunction

    logic                  mode_reg;
    height_t               upper_reg;
    height_t               lower_reg;
    tol_t                  tol_reg;
    step_t                 last_reg;
    step_t                 step_reg, step_next;
    row_t                  r0_reg, r0_next;
    row_t                  r2_reg, r2_next;
    row_t                  r4_reg, r4_next;
    height_t               fill_reg, fill_next;
    logic [TABLE_ROWS-1:0] valid_a_reg, valid_a_next;
    logic [TABLE_ROWS-1:0] valid_b_reg, valid_b_next;

    logic                  s1_valid_reg, s1_valid_next;
    height_t               s1_c_reg [4];
    step_t                 s1_step_reg;
    logic                  s1_done_reg;
    height_t               s1_fill_reg;
    logic                  s1_va_reg;
    logic                  s1_vb_reg;
    logic                  s1_fwd_a_reg;
    logic                  s1_fwd_b_reg;

    logic                  out_valid_reg, out_valid_next;
    height_t               foot_reg [6];
    step_t                 step_out_reg;
    logic                  done_out_reg;
    height_t               clamped_reg [4];

    logic                  accept;
    logic                  move;
    logic                  cfg_accept;
    logic                  done;
    height_t               c [4];
    pair_t                 rd_a;
    pair_t                 rd_b;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign move       = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !move;
    assign accept     = item_valid && !item_stall;
    assign done       = (step_reg == last_reg);

    assign c[0] = shape(height_a, mode_reg, upper_reg, lower_reg, tol_reg);
    assign c[1] = shape(height_b, mode_reg, upper_reg, lower_reg, tol_reg);
    assign c[2] = shape(height_c, mode_reg, upper_reg, lower_reg, tol_reg);
    assign c[3] = shape(height_d, mode_reg, upper_reg, lower_reg, tol_reg);

    fhss_ram #(.WIDTH(PAIR_BITS), .DEPTH(TABLE_ROWS)) u_ram_a (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (r4_reg),
        .wr_data ({c[3], c[1]}),
        .rd_en   (accept),
        .rd_addr (r0_reg),
        .rd_data (rd_a)
    );

    fhss_ram #(.WIDTH(PAIR_BITS), .DEPTH(TABLE_ROWS)) u_ram_b (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (r2_reg),
        .wr_data ({c[2], c[0]}),
        .rd_en   (accept),
        .rd_addr (r0_reg),
        .rd_data (rd_b)
    );

    always_comb
    begin
        step_next    = step_reg;
        r0_next      = r0_reg;
        r2_next      = r2_reg;
        r4_next      = r4_reg;
        fill_next    = fill_reg;
        valid_a_next = valid_a_reg;
        valid_b_next = valid_b_reg;
        if (cfg_accept && (cfg_index == REG_MODE))
        begin
            fill_next    = cfg_data[0] ? upper_reg : lower_reg;
            valid_a_next = '0;
            valid_b_next = '0;
        end
        if (accept)
        begin
            step_next = done ? '0 : step_reg + STEP_BITS'(1);
            if (step_next == '0)
            begin
                r0_next = '0;
                r2_next = ROW_OFS_2;
                r4_next = ROW_OFS_4;
            end
            else
            begin
                r0_next = (r0_reg == ROW_LAST) ? '0 : r0_reg + ROW_BITS'(1);
                r2_next = (r2_reg == ROW_LAST) ? '0 : r2_reg + ROW_BITS'(1);
                r4_next = (r4_reg == ROW_LAST) ? '0 : r4_reg + ROW_BITS'(1);
            end
            if (done)
            begin
                fill_next    = mode_reg ? upper_reg : lower_reg;
                valid_a_next = '0;
                valid_b_next = '0;
            end
            else
            begin
                valid_a_next[r4_reg] = 1'b1;
                valid_b_next[r2_reg] = 1'b1;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (move)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_RESET;
            upper_reg     <= UPPER_RESET;
            lower_reg     <= LOWER_RESET;
            tol_reg       <= TOLERANCE_RESET;
            last_reg      <= LAST_STEP_RESET;
            step_reg      <= '0;
            r0_reg        <= '0;
            r2_reg        <= ROW_OFS_2;
            r4_reg        <= ROW_OFS_4;
            fill_reg      <= MODE_RESET ? UPPER_RESET : LOWER_RESET;
            valid_a_reg   <= '0;
            valid_b_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_accept)
            begin
                unique case (cfg_index)
                    REG_MODE:      mode_reg  <= cfg_data[0];
                    REG_UPPER:     upper_reg <= height_t'(cfg_data);
                    REG_LOWER:     lower_reg <= height_t'(cfg_data);
                    REG_TOLERANCE: tol_reg   <= cfg_data[TOL_BITS-1:0];
                    REG_LAST_STEP: last_reg  <= cfg_data[STEP_BITS-1:0];
                    default: ;
                endcase
            end
            step_reg      <= step_next;
            r0_reg        <= r0_next;
            r2_reg        <= r2_next;
            r4_reg        <= r4_next;
            fill_reg      <= fill_next;
            valid_a_reg   <= valid_a_next;
            valid_b_reg   <= valid_b_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 4; i++)
            begin
                s1_c_reg[i] <= c[i];
            end
            s1_step_reg  <= step_reg;
            s1_done_reg  <= done;
            s1_fill_reg  <= fill_reg;
            s1_va_reg    <= valid_a_reg[r0_reg];
            s1_vb_reg    <= valid_b_reg[r0_reg];
            s1_fwd_a_reg <= (r4_reg == r0_reg);
            s1_fwd_b_reg <= (r2_reg == r0_reg);
        end
        if (move)
        begin
            foot_reg[0]  <= s1_fwd_a_reg ? s1_c_reg[1] : (s1_va_reg ? rd_a.lo : s1_fill_reg);
            foot_reg[3]  <= s1_fwd_a_reg ? s1_c_reg[3] : (s1_va_reg ? rd_a.hi : s1_fill_reg);
            foot_reg[1]  <= s1_fwd_b_reg ? s1_c_reg[0] : (s1_vb_reg ? rd_b.lo : s1_fill_reg);
            foot_reg[4]  <= s1_fwd_b_reg ? s1_c_reg[2] : (s1_vb_reg ? rd_b.hi : s1_fill_reg);
            foot_reg[2]  <= s1_c_reg[1];
            foot_reg[5]  <= s1_c_reg[3];
            step_out_reg <= s1_step_reg;
            done_out_reg <= s1_done_reg;
            for (int i = 0; i < 4; i++)
            begin
                clamped_reg[i] <= s1_c_reg[i];
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign foot_0       = foot_reg[0];
    assign foot_1       = foot_reg[1];
    assign foot_2       = foot_reg[2];
    assign foot_3       = foot_reg[3];
    assign foot_4       = foot_reg[4];
    assign foot_5       = foot_reg[5];
    assign step_number  = step_out_reg;
    assign run_done     = done_out_reg;
    assign clamped_a    = clamped_reg[0];
    assign clamped_b    = clamped_reg[1];
    assign clamped_c    = clamped_reg[2];
    assign clamped_d    = clamped_reg[3];

endmodule

### src/fhss_ram.sv
module fhss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/fhss_checker.sv
module fhss_checker
    import fhss_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input logic    result_valid,
    input logic    result_stall,
    input height_t foot_2,
    input height_t foot_5,
    input height_t clamped_b,
    input height_t clamped_d,
    input step_t   step_number
);

    // hold a stalled result word
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(step_number))
        else $error("stalled result word changed");

    // stall items only behind a stalled result word
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("item stall without result backpressure");

    // expect a valid result word after an accepted item, behind the stage and output registers
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> ##1 result_valid)
        else $error("accepted item produced no result word");

    // show the current step on feet two and five
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (foot_2 == clamped_b) && (foot_5 == clamped_d))
        else $error("feet two and five differ from current clamped heights");

endmodule

bind foot_height_step_schedule_top fhss_checker u_fhss_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 100ps

import fhss_pkg::*;

typedef struct {
    height_t foot [6];
    step_t   step;
    logic    done;
    height_t clamp [4];
} step_word_t;

class step_scoreboard;
    logic       mode;
    int         upper;
    int         lower;
    int         tol;
    step_t      last_step;
    step_t      counter;
    height_t    grid [TABLE_ROWS][6];
    step_word_t expected_q [$];
    int         errors;

    function new();
        errors    = 0;
        mode      = MODE_RESET;
        upper     = UPPER_RESET;
        lower     = LOWER_RESET;
        tol       = TOLERANCE_RESET;
        last_step = LAST_STEP_RESET;
        counter   = '0;
        refill();
    endfunction

    function void refill();
        height_t fill;
        fill = height_t'(mode ? upper : lower);
        for (int r = 0; r < TABLE_ROWS; r++)
        begin
            for (int f = 0; f < 6; f++)
            begin
                grid[r][f] = fill;
            end
        end
    endfunction

    function height_t shape(height_t h);
        int v;
        int target;
        int gap;
        v      = h;
        target = mode ? lower : upper;
        gap    = v - target;
        if (gap < 0)
            gap = -gap;
        if (gap < tol)
            v = target;
        if (!mode)
        begin
            if (v > upper) v = upper;
            if (v < lower) v = lower;
        end
        else
        begin
            if (v < lower) v = lower;
            if (v > upper) v = upper;
        end
        return height_t'(v);
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_MODE:
            begin
                mode = data[0];
                refill();
            end
            REG_UPPER:     upper = $signed(data);
            REG_LOWER:     lower = $signed(data);
            REG_TOLERANCE: tol = int'(data[TOL_BITS-1:0]);
            REG_LAST_STEP: last_step = data[STEP_BITS-1:0];
            default:       ;
        endcase
    endfunction

    function void note_item(height_t a, height_t b, height_t c, height_t d);
        step_word_t w;
        height_t    cl [4];
        int         r0;
        int         r2;
        int         r4;
        cl[0] = shape(a);
        cl[1] = shape(b);
        cl[2] = shape(c);
        cl[3] = shape(d);
        r0 = int'(counter) % TABLE_ROWS;
        r2 = (int'(counter) + 2) % TABLE_ROWS;
        r4 = (int'(counter) + 4) % TABLE_ROWS;
        grid[r4][0] = cl[1];
        grid[r2][1] = cl[0];
        grid[r0][2] = cl[1];
        grid[r4][3] = cl[3];
        grid[r2][4] = cl[2];
        grid[r0][5] = cl[3];
        for (int f = 0; f < 6; f++)
        begin
            w.foot[f] = grid[r0][f];
        end
        for (int i = 0; i < 4; i++)
        begin
            w.clamp[i] = cl[i];
        end
        w.step = counter;
        w.done = (counter == last_step);
        expected_q.push_back(w);
        if (w.done)
        begin
            counter = '0;
            refill();
        end
        else
        begin
            counter = counter + 1'b1;
        end
    endfunction

    function void compare(string field, logic signed [31:0] want, logic signed [31:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        end
    endfunction

    function void check_result(step_word_t got);
        step_word_t want;
        string      clamp_name [4];
        clamp_name = '{"clamped_a", "clamped_b", "clamped_c", "clamped_d"};
        if (expected_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("result word with no step pending, step_number %0d", got.step);
            return;
        end
        want = expected_q.pop_front();
        for (int f = 0; f < 6; f++)
        begin
            compare($sformatf("foot_%0d", f), want.foot[f], got.foot[f]);
        end
        compare("step_number", {29'd0, want.step}, {29'd0, got.step});
        compare("run_done", {31'd0, want.done}, {31'd0, got.done});
        for (int i = 0; i < 4; i++)
        begin
            compare(clamp_name[i], want.clamp[i], got.clamp[i]);
        end
    endfunction

    function int wrap_up();
        if (expected_q.size() != 0)
        begin
            $display("%0d step words never came out", expected_q.size());
            errors += expected_q.size();
        end
        return errors;
    endfunction
endclass

module tb_top;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 179;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     item_valid;
    logic                     item_stall;
    height_t                  height_a;
    height_t                  height_b;
    height_t                  height_c;
    height_t                  height_d;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    height_t                  foot_0;
    height_t                  foot_1;
    height_t                  foot_2;
    height_t                  foot_3;
    height_t                  foot_4;
    height_t                  foot_5;
    step_t                    step_number;
    logic                     run_done;
    height_t                  clamped_a;
    height_t                  clamped_b;
    height_t                  clamped_c;
    height_t                  clamped_d;
    logic                     cfg_valid;
    logic                     cfg_ready;
    cfg_index_t               cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    logic           src_idle_en;
    logic           snk_stall_en = 1'b1;
    int             quiet_cycles = 0;
    step_scoreboard sb;

    foot_height_step_schedule_top u_dut (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        result_stall <= snk_stall_en && ($urandom_range(0, 99) < 30);
    end

    always @(posedge clk)
    begin : monitor
        step_word_t got;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                sb.note_item(height_a, height_b, height_c, height_d);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (result_valid && !result_stall)
            begin
                got.foot[0]  = foot_0;
                got.foot[1]  = foot_1;
                got.foot[2]  = foot_2;
                got.foot[3]  = foot_3;
                got.foot[4]  = foot_4;
                got.foot[5]  = foot_5;
                got.step     = step_number;
                got.done     = run_done;
                got.clamp[0] = clamped_a;
                got.clamp[1] = clamped_b;
                got.clamp[2] = clamped_c;
                got.clamp[3] = clamped_d;
                sb.check_result(got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(height_t a, height_t b, height_t c, height_t d);
        while (src_idle_en && ($urandom_range(0, 99) < 30))
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        height_a   <= a;
        height_b   <= b;
        height_c   <= c;
        height_d   <= d;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // hold the sender until every pending step word is out
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic height_t pick_height();
        int base;
        int off;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return height_t'($urandom);
        if (sel == 3)
            return $urandom_range(0, 1) ? height_t'(32767) : height_t'(-32768);
        if (sel == 4 && sb.lower < sb.upper)
            return height_t'(sb.lower + $urandom_range(0, sb.upper - sb.lower));
        base = $urandom_range(0, 1) ? sb.upper : sb.lower;
        case ($urandom_range(0, 4))
            0:       off = 0;
            1:       off = sb.tol - 1;
            2:       off = sb.tol;
            3:       off = sb.tol + 1;
            default: off = $urandom_range(0, sb.tol + 64);
        endcase
        if ($urandom_range(0, 1))
            off = -off;
        return height_t'(base + off);
    endfunction

    task automatic new_setting(int phase);
        int    hi_v;
        int    lo_v;
        int    tol_v;
        int    swap_v;
        int    sel;
        logic  mode_v;
        logic  mode_first;
        step_t last_v;
        sel = (phase == 1) ? 0 : $urandom_range(0, 5);
        case (sel)
            0:
            begin
                hi_v = 32767;
                lo_v = -32768;
            end
            1:
            begin
                lo_v = $urandom_range(0, 20000);
                hi_v = lo_v - $urandom_range(1, 30000);
            end
            2:
            begin
                lo_v = $urandom_range(0, 65535) - 32768;
                hi_v = lo_v;
            end
            default:
            begin
                hi_v = $urandom_range(0, 65535) - 32768;
                lo_v = $urandom_range(0, 65535) - 32768;
                if (lo_v > hi_v)
                begin
                    swap_v = lo_v;
                    lo_v   = hi_v;
                    hi_v   = swap_v;
                end
            end
        endcase
        case ($urandom_range(0, 3))
            0:       tol_v = 0;
            1:       tol_v = 32767;
            2:       tol_v = $urandom_range(0, 3000);
            default: tol_v = $urandom_range(0, 32767);
        endcase
        last_v = $urandom_range(0, 7);
        if (phase == 0)
            last_v = '0;
        if (phase == 2)
            last_v = '1;
        mode_v     = $urandom_range(0, 1);
        mode_first = $urandom_range(0, 1);
        if (mode_first)
            write_reg(REG_MODE, {15'd0, mode_v});
        write_reg(REG_UPPER, 16'(hi_v));
        write_reg(REG_LOWER, 16'(lo_v));
        write_reg(REG_TOLERANCE, 16'(tol_v));
        write_reg(REG_LAST_STEP, {13'd0, last_v});
        if (!mode_first)
            write_reg(REG_MODE, {15'd0, mode_v});
        if ($urandom_range(0, 3) == 0)
            write_reg(cfg_index_t'(REG_LAST_STEP + 1 + $urandom_range(0, 2)), 16'($urandom));
    endtask

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        height_a    = '0;
        height_b    = '0;
        height_c    = '0;
        height_d    = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_MODE;
        cfg_data    = '0;
        src_idle_en = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // step up with reset bounds: extremes, snap edges, clamp edges, run end
        send_item(16'sh7FFF, 16'sh8000, 16'sd0, -16'sd1);
        send_item(-16'sd8500, -16'sd8849, -16'sd8850, -16'sd8851);
        send_item(-16'sd8151, -16'sd8150, -16'sd10500, -16'sd10501);
        send_item(-16'sd10499, -16'sd9500, -16'sd10850, 16'sh5555);
        send_item(-16'sd9000, 16'shAAAA, -16'sd8500, -16'sd9999);
        settle();

        // step down refills with the upper bound
        write_reg(REG_MODE, 16'd1);
        send_item(-16'sd10151, -16'sd10150, -16'sd10849, -16'sd10850);
        send_item(16'sh7FFF, 16'sh8000, -16'sd9000, -16'sd8499);
        send_item(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        settle();

        // crossed bounds in both modes
        write_reg(REG_UPPER, -16'sd100);
        write_reg(REG_LOWER, 16'sd100);
        write_reg(REG_MODE, 16'd0);
        send_item(-16'sd5000, 16'sd5000, 16'sd0, 16'sd99);
        send_item(16'sh7FFF, 16'sh8000, -16'sd100, 16'sd100);
        settle();
        write_reg(REG_MODE, 16'd1);
        send_item(-16'sd5000, 16'sd5000, 16'sd0, 16'sd99);
        send_item(16'sh7FFF, 16'sh8000, -16'sd100, 16'sd100);
        settle();

        // lower the last step under the running counter so it wraps around
        write_reg(REG_UPPER, 16'sd1000);
        write_reg(REG_LOWER, -16'sd1000);
        write_reg(REG_LAST_STEP, 16'd7);
        write_reg(REG_MODE, 16'd0);
        repeat (4) send_item(pick_height(), pick_height(), pick_height(), pick_height());
        settle();
        write_reg(REG_LAST_STEP, 16'd1);
        for (int k = 1; k <= 3; k++)
            write_reg(cfg_index_t'(REG_LAST_STEP + k), 16'hFFFF);
        repeat (6) send_item(pick_height(), pick_height(), pick_height(), pick_height());
        settle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            new_setting(phase);
            src_idle_en  = (phase != 3);
            snk_stall_en <= (phase != 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 5 && n == PHASE_ITEMS / 2)
                    settle();
                send_item(pick_height(), pick_height(), pick_height(), pick_height());
            end
            settle();
        end

        snk_stall_en <= 1'b1;
        settle();
        repeat (6) @(posedge clk);
        if (sb.wrap_up() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

### foot_height_step_schedule_top.f
src/fhss_pkg.sv
src/fhss_ram.sv
src/foot_height_step_schedule_top.sv
src/fhss_checker.sv
sim/tb_top.sv
